[hw/rtl/mh2_pkg.sv]
// ----------------------------------------------------------------------------
// MurmurHash2 package
// Shared constants and the item record that passes from the front end to the
// back end.
// ----------------------------------------------------------------------------
package mh2_pkg;

	localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
	localparam int unsigned MIX_SHIFT   = 24;
	localparam int unsigned FIN_SHIFT_A = 13;
	localparam int unsigned FIN_SHIFT_B = 15;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_FULL = 2'd1;
	localparam logic [1:0] KIND_TAIL = 2'd2;

	typedef logic [1:0] mh2_kind_t;

	typedef struct packed {
		mh2_kind_t   kind;
		logic [31:0] key;
		logic        first;
		logic        last;
		logic [31:0] length;
	} mh2_entry_t;

endpackage

[hw/rtl/mh2_if.sv]
// ----------------------------------------------------------------------------
// MurmurHash2 channels
// Valid/ready channels for message words and finished hashes.
// ----------------------------------------------------------------------------
interface mh2_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] data_word;
	logic [2:0]  byte_count;
	logic        first_word;
	logic        last_word;
	logic [31:0] message_length;

	modport source (
		output valid, data_word, byte_count, first_word, last_word, message_length,
		input  ready
	);
	modport sink (
		input  valid, data_word, byte_count, first_word, last_word, message_length,
		output ready
	);
endinterface

interface mh2_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] hash_value;

	modport source (
		output valid, hash_value,
		input  ready
	);
	modport sink (
		input  valid, hash_value,
		output ready
	);
endinterface

[hw/rtl/mh2_front.sv]
// ----------------------------------------------------------------------------
// MurmurHash2 front end
// Accepts words, classifies them as full, tail or empty, and mixes full keys
// in a three-stage pipeline.
// ----------------------------------------------------------------------------
module mh2_front (
	input  logic              clk,
	input  logic              arst_n,
	mh2_in_if.sink            in_ch,
	output mh2_pkg::mh2_entry_t push_entry,
	output logic              push_valid,
	input  logic              push_ready
);
	import mh2_pkg::*;

	logic       v_s1, v_s2, v_s3;
	mh2_entry_t e_s1, e_s2, e_s3;
	mh2_entry_t e_in, e2_next, e3_next;
	logic       en1, en2, en3;
	logic [31:0] mask;
	logic [31:0] key_mul;
	logic [31:0] key_mix;
	logic [31:0] key_fin;

	assign en3 = !v_s3 || push_ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ch.ready = en1;

	always_comb begin
		case (in_ch.byte_count)
			3'd1: mask = 32'h0000_00ff;
			3'd2: mask = 32'h0000_ffff;
			3'd3: mask = 32'h00ff_ffff;
			default: mask = 32'hffff_ffff;
		endcase
		e_in.first  = in_ch.first_word;
		e_in.last   = in_ch.last_word;
		e_in.length = in_ch.message_length;
		e_in.key    = in_ch.data_word & mask;
		if (in_ch.byte_count[2]) begin
			e_in.kind = KIND_FULL;
		end else if (in_ch.byte_count != 3'd0) begin
			e_in.kind = KIND_TAIL;
		end else begin
			e_in.kind = KIND_NONE;
		end
	end

	assign key_mul = e_s1.key * MIX_MUL;
	always_comb begin
		e2_next = e_s1;
		if (e_s1.kind == KIND_FULL) begin
			e2_next.key = key_mul;
		end
	end

	assign key_mix = e_s2.key ^ (e_s2.key >> MIX_SHIFT);
	assign key_fin = key_mix * MIX_MUL;
	always_comb begin
		e3_next = e_s2;
		if (e_s2.kind == KIND_FULL) begin
			e3_next.key = key_fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= in_ch.valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_ch.valid) begin
			e_s1 <= e_in;
		end
		if (en2 && v_s1) begin
			e_s2 <= e2_next;
		end
		if (en3 && v_s2) begin
			e_s3 <= e3_next;
		end
	end

	assign push_valid = v_s3;
	assign push_entry = e_s3;

endmodule

[hw/rtl/mh2_fifo.sv]
// ----------------------------------------------------------------------------
// MurmurHash2 item queue
// Short queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module mh2_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  mh2_pkg::mh2_entry_t push_entry,
	input  logic                push_valid,
	output logic                push_ready,
	output mh2_pkg::mh2_entry_t pop_entry,
	output logic                pop_valid,
	input  logic                pop_ready
);
	import mh2_pkg::*;

	mh2_entry_t         mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CW-1:0] count_q;
	logic               push_fire, pop_fire;

	assign push_ready = (count_q != FIFO_CW'(FIFO_DEPTH));
	assign pop_valid  = (count_q != FIFO_CW'(0));
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;
	assign pop_entry  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop_fire) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			if (push_fire && !pop_fire) begin
				count_q <= count_q + FIFO_CW'(1);
			end else if (pop_fire && !push_fire) begin
				count_q <= count_q - FIFO_CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_fire) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FIFO_CW'(FIFO_DEPTH))
		else $error("Queue count exceeds its depth.");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push_fire && !pop_fire) |=> (count_q == $past(count_q) + FIFO_CW'(1)))
		else $error("Queue count did not follow a lone push.");
`endif

endmodule

[hw/rtl/mh2_back.sv]
// ----------------------------------------------------------------------------
// MurmurHash2 back end
// Runs the hash recurrence on queued items and the final avalanche, sharing
// one multiplier, and holds the finished hash in an output register.
// ----------------------------------------------------------------------------
module mh2_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [31:0]         hash_seed,
	input  mh2_pkg::mh2_entry_t pop_entry,
	input  logic                pop_valid,
	output logic                pop_ready,
	mh2_out_if.source           out_ch
);
	import mh2_pkg::*;

	localparam logic [1:0] ST_RUN  = 2'd0;
	localparam logic [1:0] ST_AVAL = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]  state_q;
	logic [31:0] hash_q;
	logic [31:0] aval_q;
	logic [31:0] out_hash_q;
	logic        out_valid_q;
	logic [31:0] h0, mul_a, mul_p, h_new;
	logic        fin_load;

	assign pop_ready = (state_q == ST_RUN);
	assign h0 = pop_entry.first ? (hash_seed ^ pop_entry.length) : hash_q;

	always_comb begin
		case (state_q)
			ST_AVAL: mul_a = hash_q ^ (hash_q >> FIN_SHIFT_A);
			default: mul_a = (pop_entry.kind == KIND_TAIL) ? (h0 ^ pop_entry.key) : h0;
		endcase
	end

	assign mul_p = mul_a * MIX_MUL;

	always_comb begin
		case (pop_entry.kind)
			KIND_FULL: h_new = mul_p ^ pop_entry.key;
			KIND_TAIL: h_new = mul_p;
			default:   h_new = h0;
		endcase
	end

	assign fin_load = (state_q == ST_FIN) && (!out_valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			hash_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_RUN: begin
					if (pop_valid) begin
						hash_q <= h_new;
						if (pop_entry.last) begin
							state_q <= ST_AVAL;
						end
					end
				end
				ST_AVAL: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_load) begin
						state_q <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_AVAL) begin
			aval_q <= mul_p;
		end
		if (fin_load) begin
			out_hash_q <= aval_q ^ (aval_q >> FIN_SHIFT_B);
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.hash_value = out_hash_q;

`ifndef SYNTH
	a_aval_to_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_AVAL) |=> (state_q == ST_FIN))
		else $error("Avalanche step was not followed by the finish step.");
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("A hash was presented without passing the finish step.");
`endif

endmodule

[hw/rtl/murmur2_hash_32_unit.sv]
// ----------------------------------------------------------------------------
// MurmurHash2 32-bit hash unit
// Streams little-endian message words and returns the 32-bit hash of each
// message on its last word.
// ----------------------------------------------------------------------------
// A message word is taken every cycle while the internal queue has room. Key
// mixing runs in a three-stage front pipeline; in its run state the back end
// folds one word per cycle into the running hash through its single shared
// multiplier. After the last word of a message it runs the avalanche step,
// then the finish step, which loads the hash into the output register, and
// takes no new word until then. The user writes the seed through cfg_wr_en
// and cfg_wr_data while the unit is idle; the unit does not enforce this.
module murmur2_hash_32_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	mh2_in_if.sink      in_ch,
	mh2_out_if.source   out_ch
);
	import mh2_pkg::*;

	logic [31:0] hash_seed_q;
	mh2_entry_t  push_entry, pop_entry;
	logic        push_valid, push_ready;
	logic        pop_valid, pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_seed_q <= '0;
		end else if (cfg_wr_en) begin
			hash_seed_q <= cfg_wr_data;
		end
	end

	mh2_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.push_entry (push_entry),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	mh2_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_entry (push_entry),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_entry  (pop_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	mh2_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.hash_seed (hash_seed_q),
		.pop_entry (pop_entry),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.out_ch    (out_ch)
	);

endmodule
